### rtl/core/ddm_pkg.sv
// ----------------------------------------------------------------------------
// ddm_pkg: shared types and constants of the differential drive mixer
// Field widths, fixed scaling constants and the controller/datapath interface.
// ----------------------------------------------------------------------------
package ddm_pkg;

	localparam int IN_W      = 11;         // signed request width
	localparam int DUTY_W    = 10;         // duty compare width
	localparam int MAG_W     = 11;         // magnitudes up to twice the duty limit
	localparam int MIX_W     = MAG_W + 1;  // signed mixed speed
	localparam int PROD_W    = 22;         // dividend width, even for two bits a cycle
	localparam int DIV_STEPS = PROD_W / 2;
	localparam int TIMEOUT_W = 16;

	localparam logic [MAG_W-1:0]     DUTY_MAX      = 11'd999;
	localparam logic [MAG_W-1:0]     FULL_SCALE    = 11'd1000;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd300;

	typedef enum logic {
		DIV_LEFT,
		DIV_RIGHT
	} div_sel_t;

	typedef struct packed {
		logic     latch_in;
		logic     div_start;
		logic     div_store;
		div_sel_t div_sel;
		logic     mix;
		logic     commit_cmd;
		logic     commit_tick;
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_done;
		logic need_scale;
	} dp_status_t;

endpackage

### rtl/core/ddm_divider.sv
// ----------------------------------------------------------------------------
// ddm_divider: restoring unsigned divider
// Retires two quotient bits per cycle; done pulses when the quotient is final.
// ----------------------------------------------------------------------------
module ddm_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ddm_pkg::PROD_W-1:0]  num,
	input  logic [ddm_pkg::MAG_W-1:0]   den,
	output logic                        done,
	output logic [ddm_pkg::PROD_W-1:0]  quot
);

	localparam int CNT_W = $clog2(ddm_pkg::DIV_STEPS + 1);

	logic [ddm_pkg::PROD_W-1:0] quot_q;
	logic [ddm_pkg::MAG_W-1:0]  rem_q;
	logic [ddm_pkg::MAG_W-1:0]  den_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [ddm_pkg::MAG_W:0]    step1;
	logic [ddm_pkg::MAG_W:0]    step2;

	// One restoring step: returns the quotient bit above the new remainder.
	function automatic logic [ddm_pkg::MAG_W:0] div_step(
		logic [ddm_pkg::MAG_W-1:0] rem,
		logic                      nbit,
		logic [ddm_pkg::MAG_W-1:0] d
	);
		logic [ddm_pkg::MAG_W:0] trial;
		logic [ddm_pkg::MAG_W:0] diff;
		trial = {rem, nbit};
		diff  = trial - {1'b0, d};
		if (trial >= {1'b0, d}) begin
			return {1'b1, diff[ddm_pkg::MAG_W-1:0]};
		end
		return {1'b0, trial[ddm_pkg::MAG_W-1:0]};
	endfunction

	assign step1 = div_step(rem_q, quot_q[ddm_pkg::PROD_W-1], den_q);
	assign step2 = div_step(step1[ddm_pkg::MAG_W-1:0], quot_q[ddm_pkg::PROD_W-2], den_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ddm_pkg::DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (busy_q) begin
			quot_q <= {quot_q[ddm_pkg::PROD_W-3:0], step1[ddm_pkg::MAG_W],
				step2[ddm_pkg::MAG_W]};
			rem_q  <= step2[ddm_pkg::MAG_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

### rtl/core/ddm_datapath.sv
// ----------------------------------------------------------------------------
// ddm_datapath: scaling, mixing, drive registers and watchdog
// Holds the request operands, feeds the shared divider and updates the motors.
// ----------------------------------------------------------------------------
module ddm_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ddm_pkg::ctrl_cmd_t                cmd,
	output ddm_pkg::dp_status_t               status,
	input  logic                              cfg_write,
	input  logic [ddm_pkg::TIMEOUT_W-1:0]     cfg_data,
	input  logic signed [ddm_pkg::IN_W-1:0]   throttle,
	input  logic signed [ddm_pkg::IN_W-1:0]   steering,
	output logic                              left_forward,
	output logic [ddm_pkg::DUTY_W-1:0]        left_duty,
	output logic                              right_forward,
	output logic [ddm_pkg::DUTY_W-1:0]        right_duty,
	output logic                              timed_out
);

	localparam int MAG_W = ddm_pkg::MAG_W;
	localparam int MIX_W = ddm_pkg::MIX_W;

	// Sign and clamped magnitude of a request.
	function automatic logic [MAG_W:0] clamp_in(logic signed [ddm_pkg::IN_W-1:0] x);
		logic [ddm_pkg::IN_W:0] ext;
		logic [ddm_pkg::IN_W:0] mag;
		ext = {x[ddm_pkg::IN_W-1], x};
		mag = x[ddm_pkg::IN_W-1] ? (~ext + 1'b1) : ext;
		if (mag > (ddm_pkg::IN_W + 1)'(ddm_pkg::FULL_SCALE)) begin
			mag = (ddm_pkg::IN_W + 1)'(ddm_pkg::FULL_SCALE);
		end
		return {x[ddm_pkg::IN_W-1], mag[MAG_W-1:0]};
	endfunction

	function automatic logic signed [MIX_W-1:0] apply_sign(logic neg, logic [MAG_W-1:0] m);
		logic [MIX_W-1:0] ext;
		ext = {1'b0, m};
		return neg ? -ext : ext;
	endfunction

	// The duty limit is one below full scale, so for a clamped magnitude m the
	// truncated m * DUTY_MAX / FULL_SCALE is m - 1 whenever m is nonzero.
	function automatic logic signed [MIX_W-1:0] scale_in(logic signed [ddm_pkg::IN_W-1:0] x);
		logic [MAG_W:0]   c;
		logic [MAG_W-1:0] m;
		c = clamp_in(x);
		m = (c[MAG_W-1:0] == '0) ? '0 : (c[MAG_W-1:0] - 1'b1);
		return apply_sign(c[MAG_W], m);
	endfunction

	function automatic logic [MAG_W-1:0] abs_mix(logic signed [MIX_W-1:0] v);
		logic [MIX_W-1:0] neg_v;
		neg_v = -v;
		return v[MIX_W-1] ? neg_v[MAG_W-1:0] : v[MAG_W-1:0];
	endfunction

	// Direction and duty of one side; a zero speed drives forward.
	function automatic logic [ddm_pkg::DUTY_W:0] drive_side(logic signed [MIX_W-1:0] v);
		logic [MAG_W-1:0] mag;
		mag = abs_mix(v);
		if (mag > ddm_pkg::DUTY_MAX) begin
			mag = ddm_pkg::DUTY_MAX;
		end
		return {~v[MIX_W-1], mag[ddm_pkg::DUTY_W-1:0]};
	endfunction

	logic signed [MIX_W-1:0]         thr_in;
	logic signed [MIX_W-1:0]         str_in;
	logic signed [MIX_W-1:0]         thr_q;
	logic signed [MIX_W-1:0]         str_q;
	logic signed [MIX_W-1:0]         l_q;
	logic signed [MIX_W-1:0]         r_q;
	logic [MAG_W-1:0]                mm_q;
	logic signed [MIX_W-1:0]         mix_l;
	logic signed [MIX_W-1:0]         mix_r;
	logic [MAG_W-1:0]                mix_al;
	logic [MAG_W-1:0]                mix_ar;
	logic [MAG_W-1:0]                mix_mm;
	logic [MAG_W-1:0]                op_mag;
	logic [MAG_W-1:0]                op_den;
	logic                            op_neg;
	logic [ddm_pkg::PROD_W-1:0]      div_num;
	logic [ddm_pkg::PROD_W-1:0]      div_quot;
	logic                            div_done;
	logic signed [MIX_W-1:0]         quot_signed;
	logic [ddm_pkg::DUTY_W:0]        left_next;
	logic [ddm_pkg::DUTY_W:0]        right_next;
	logic [ddm_pkg::TIMEOUT_W-1:0]   timeout_q;
	logic [ddm_pkg::TIMEOUT_W-1:0]   age_q;
	logic                            armed_q;
	logic                            left_dir_q;
	logic                            right_dir_q;
	logic [ddm_pkg::DUTY_W-1:0]      left_duty_q;
	logic [ddm_pkg::DUTY_W-1:0]      right_duty_q;
	logic                            timed_out_q;

	assign thr_in = scale_in(throttle);
	assign str_in = scale_in(steering);

	assign mix_l  = thr_q + str_q;
	assign mix_r  = thr_q - str_q;
	assign mix_al = abs_mix(mix_l);
	assign mix_ar = abs_mix(mix_r);
	assign mix_mm = (mix_al > mix_ar) ? mix_al : mix_ar;

	always_comb begin
		case (cmd.div_sel)
			ddm_pkg::DIV_LEFT: begin
				op_mag = abs_mix(l_q);
				op_den = mm_q;
				op_neg = l_q[MIX_W-1];
			end
			default: begin
				op_mag = abs_mix(r_q);
				op_den = mm_q;
				op_neg = r_q[MIX_W-1];
			end
		endcase
	end

	assign div_num     = ddm_pkg::PROD_W'(op_mag) * ddm_pkg::PROD_W'(ddm_pkg::DUTY_MAX);
	assign quot_signed = apply_sign(op_neg, div_quot[MAG_W-1:0]);

	ddm_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (op_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			thr_q <= thr_in;
			str_q <= str_in;
		end
		if (cmd.div_store) begin
			case (cmd.div_sel)
				ddm_pkg::DIV_LEFT: l_q <= quot_signed;
				default:           r_q <= quot_signed;
			endcase
		end
		if (cmd.mix) begin
			l_q  <= mix_l;
			r_q  <= mix_r;
			mm_q <= mix_mm;
		end
	end

	assign left_next  = drive_side(l_q);
	assign right_next = drive_side(r_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q    <= ddm_pkg::TIMEOUT_RESET;
			age_q        <= '0;
			armed_q      <= 1'b0;
			left_dir_q   <= 1'b0;
			right_dir_q  <= 1'b0;
			left_duty_q  <= '0;
			right_duty_q <= '0;
			timed_out_q  <= 1'b0;
		end else begin
			if (cfg_write) begin
				timeout_q <= cfg_data;
			end
			if (cmd.commit_cmd) begin
				left_dir_q   <= left_next[ddm_pkg::DUTY_W];
				left_duty_q  <= left_next[ddm_pkg::DUTY_W-1:0];
				right_dir_q  <= right_next[ddm_pkg::DUTY_W];
				right_duty_q <= right_next[ddm_pkg::DUTY_W-1:0];
				armed_q      <= 1'b1;
				age_q        <= '0;
				timed_out_q  <= 1'b0;
			end else if (cmd.commit_tick) begin
				timed_out_q <= 1'b0;
				if (armed_q) begin
					if (age_q >= timeout_q) begin
						left_dir_q   <= 1'b0;
						left_duty_q  <= '0;
						right_dir_q  <= 1'b0;
						right_duty_q <= '0;
						armed_q      <= 1'b0;
						timed_out_q  <= 1'b1;
					end else begin
						age_q <= age_q + 1'b1;
					end
				end
			end
		end
	end

	assign status.div_done   = div_done;
	assign status.need_scale = (mix_mm > ddm_pkg::DUTY_MAX);

	assign left_forward  = left_dir_q;
	assign left_duty     = left_duty_q;
	assign right_forward = right_dir_q;
	assign right_duty    = right_duty_q;
	assign timed_out     = timed_out_q;

endmodule

### rtl/core/ddm_ctrl.sv
// ----------------------------------------------------------------------------
// ddm_ctrl: sequencing controller
// Accepts one request at a time, steps the divider passes and commits results.
// ----------------------------------------------------------------------------
module ddm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	input  logic                 operation,
	output logic                 cmd_stall,
	output logic                 res_valid,
	input  logic                 res_stall,
	input  ddm_pkg::dp_status_t  status,
	output ddm_pkg::ctrl_cmd_t   cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TICK_WR,
		ST_MIX,
		ST_DIV_L,
		ST_WAIT_L,
		ST_DIV_R,
		ST_WAIT_R,
		ST_CMD_WR
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   res_valid_q;
	logic   slot_free;

	// The drive registers are the result, so they change only once the last
	// result has been taken.
	assign slot_free = !res_valid_q || !res_stall;

	always_comb begin
		cmd         = '0;
		cmd.div_sel = ddm_pkg::DIV_LEFT;
		state_d     = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = operation ? ST_TICK_WR : ST_MIX;
				end
			end
			ST_TICK_WR: begin
				if (slot_free) begin
					cmd.commit_tick = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			ST_MIX: begin
				cmd.mix = 1'b1;
				state_d = status.need_scale ? ST_DIV_L : ST_CMD_WR;
			end
			ST_DIV_L: begin
				cmd.div_sel   = ddm_pkg::DIV_LEFT;
				cmd.div_start = 1'b1;
				state_d       = ST_WAIT_L;
			end
			ST_WAIT_L: begin
				cmd.div_sel = ddm_pkg::DIV_LEFT;
				if (status.div_done) begin
					cmd.div_store = 1'b1;
					state_d       = ST_DIV_R;
				end
			end
			ST_DIV_R: begin
				cmd.div_sel   = ddm_pkg::DIV_RIGHT;
				cmd.div_start = 1'b1;
				state_d       = ST_WAIT_R;
			end
			ST_WAIT_R: begin
				cmd.div_sel = ddm_pkg::DIV_RIGHT;
				if (status.div_done) begin
					cmd.div_store = 1'b1;
					state_d       = ST_CMD_WR;
				end
			end
			ST_CMD_WR: begin
				if (slot_free) begin
					cmd.commit_cmd = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit_cmd || cmd.commit_tick) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign cmd_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;

endmodule

### rtl/core/differential_drive_mixer_watchdog.sv
// Sequence: a tick is accepted, then committed to the watchdog; a drive request is mixed,
// scaled by two divider passes when the mixed speeds need normalizing, and then committed.
// Throughput: one request at a time, and a commit waits while the last result is stalled;
// the shared divider retires two quotient bits a cycle.
// Reset: arst_n clears the watchdog, stops both motors and loads a timeout of 300 ticks.
// ----------------------------------------------------------------------------
// differential_drive_mixer_watchdog: arcade drive mixer with command watchdog
// Mixes throttle and steering into two motor directions and duties and stops
// both motors when ticks keep arriving without a new drive request.
// ----------------------------------------------------------------------------
module differential_drive_mixer_watchdog (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmd_valid,
	output logic                              cmd_stall,
	input  logic                              operation,
	input  logic signed [ddm_pkg::IN_W-1:0]   throttle,
	input  logic signed [ddm_pkg::IN_W-1:0]   steering,
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic                              left_forward,
	output logic [ddm_pkg::DUTY_W-1:0]        left_duty,
	output logic                              right_forward,
	output logic [ddm_pkg::DUTY_W-1:0]        right_duty,
	output logic                              timed_out,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ddm_pkg::TIMEOUT_W-1:0]     timeout_ticks
);

	ddm_pkg::ctrl_cmd_t  cmd;
	ddm_pkg::dp_status_t status;

	// The timeout register is to be written only while idle; the block does not enforce it, so it is always ready.
	assign cfg_ready = 1'b1;

	ddm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.operation (operation),
		.cmd_stall (cmd_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.status    (status),
		.cmd       (cmd)
	);

	ddm_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_write     (cfg_valid && cfg_ready),
		.cfg_data      (timeout_ticks),
		.throttle      (throttle),
		.steering      (steering),
		.left_forward  (left_forward),
		.left_duty     (left_duty),
		.right_forward (right_forward),
		.right_duty    (right_duty),
		.timed_out     (timed_out)
	);

endmodule
